@@ rtl/histogram_3d_binning_accumulator_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 3-D histogram accumulator
// Clocked implication checks, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_3D_BINNING_ACCUMULATOR_TOP_MACROS_SVH
`define HISTOGRAM_3D_BINNING_ACCUMULATOR_TOP_MACROS_SVH

// same-cycle implication
`define H3D_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("h3d assertion failed");

// next-cycle implication
`define H3D_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("h3d assertion failed");

`endif

@@ rtl/hist3d_pkg.sv @@
// ----------------------------------------------------------------------------
// hist3d_pkg
// Shared constants, types and helpers of the 3-D histogram accumulator.
// ----------------------------------------------------------------------------
package hist3d_pkg;

    localparam int DEF_BINS_X     = 16;
    localparam int DEF_BINS_Y     = 16;
    localparam int DEF_BINS_Z     = 16;
    localparam int DEF_COUNT_BITS = 32;

    localparam int AXIS_BW  = 8;   // bin index of one axis, up to 256 bins
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 32;

    localparam logic [CFG_IW-1:0] REG_MIN_X   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_MIN_Y   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_MIN_Z   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_WIDTH_X = 3'd3;
    localparam logic [CFG_IW-1:0] REG_WIDTH_Y = 3'd4;
    localparam logic [CFG_IW-1:0] REG_WIDTH_Z = 3'd5;
    localparam logic [CFG_IW-1:0] REG_STRICT  = 3'd6;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [31:0] MIN_RESET   = 32'hFFF6_0000;
    localparam logic [30:0] WIDTH_RESET = 31'd6554;

    typedef struct packed {
        logic               done;
        logic               clamp;
        logic [AXIS_BW-1:0] bin;
    } t_lane_res;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        logic [31:0] r;
        r = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
        return r;
    endfunction

endpackage

@@ rtl/hist3d_axis_lane.sv @@
// ----------------------------------------------------------------------------
// hist3d_axis_lane
// Bins one axis: range check, then a restoring quotient one bit per cycle.
// ----------------------------------------------------------------------------
module hist3d_axis_lane
    import hist3d_pkg::*;
#(
    parameter int BINS = DEF_BINS_X
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [31:0]       i_sample,
    input  logic [31:0]       i_min,
    input  logic [30:0]       i_width,
    output t_lane_res         o_res
);

    localparam int QB = (BINS > 1) ? $clog2(BINS) : 1;
    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_CHK  = 2'd1;
    localparam logic [1:0] L_DIV  = 2'd2;

    logic [1:0]         r_st, n_st;
    logic signed [32:0] r_d;
    logic [32:0]        r_rem;
    logic [39:0]        r_lim;
    logic [39:0]        r_div;
    logic [AXIS_BW-1:0] r_q;
    logic [3:0]         r_cnt;
    logic               r_clamp;

    logic signed [32:0] d_sub;
    logic [30:0]        w_eff;
    logic               step_ge;
    logic               d_neg;
    logic               d_high;

    assign d_sub   = $signed({i_sample[31], i_sample}) - $signed({i_min[31], i_min});
    assign w_eff   = (i_width == 31'd0) ? 31'd1 : i_width;
    assign step_ge = {7'd0, r_rem} >= r_div;
    assign d_neg   = r_d[32];
    assign d_high  = !r_d[32] && ({7'd0, r_d} >= r_lim);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            L_IDLE: if (i_start) n_st = L_CHK;
            L_CHK: begin
                if (d_neg || d_high) n_st = L_IDLE;
                else n_st = L_DIV;
            end
            L_DIV: if (r_cnt == 4'd1) n_st = L_IDLE;
            default: n_st = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= L_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            L_IDLE: begin
                if (i_start) begin
                    r_d   <= d_sub;
                    r_lim <= 40'(w_eff) * 40'(BINS);
                    r_div <= 40'(w_eff) << (QB - 1);
                end
            end
            L_CHK: begin
                r_rem   <= r_d;
                r_cnt   <= 4'(QB);
                r_clamp <= d_neg | d_high;
                // clamp high to the last bin, otherwise start the quotient at zero
                r_q     <= d_high ? AXIS_BW'(BINS - 1) : '0;
            end
            L_DIV: begin
                // one quotient bit per cycle, divisor walks right
                if (step_ge) r_rem <= r_rem - r_div[32:0];
                r_q   <= {r_q[AXIS_BW-2:0], step_ge};
                r_div <= r_div >> 1;
                r_cnt <= r_cnt - 4'd1;
            end
            default: ;
        endcase
    end

    assign o_res.done  = (r_st == L_IDLE);
    assign o_res.clamp = r_clamp;
    assign o_res.bin   = r_q;

endmodule

@@ rtl/hist3d_merge.sv @@
// ----------------------------------------------------------------------------
// hist3d_merge
// Combines the three axis bins into the flat bin and the range flag.
// ----------------------------------------------------------------------------
module hist3d_merge
    import hist3d_pkg::*;
#(
    parameter int BINS_Y = DEF_BINS_Y,
    parameter int BINS_Z = DEF_BINS_Z,
    parameter int FB     = 12
) (
    input  logic          i_clk,
    input  logic          i_load,
    input  t_lane_res     i_x,
    input  t_lane_res     i_y,
    input  t_lane_res     i_z,
    output logic [FB-1:0] o_flat,
    output logic          o_oor
);

    logic [31:0] xy;
    logic [31:0] flat;

    assign xy   = 32'(i_x.bin) * 32'(BINS_Y) + 32'(i_y.bin);
    assign flat = xy * 32'(BINS_Z) + 32'(i_z.bin);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_flat <= FB'(flat);
            o_oor  <= i_x.clamp | i_y.clamp | i_z.clamp;
        end
    end

endmodule

@@ rtl/histogram_3d_binning_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// histogram_3d_binning_accumulator_top
// 3-D histogram of Q16.16 samples with per-bin and total counters.
// ----------------------------------------------------------------------------
// One word at a time. A read word passes through S_RA and S_UPD once it is
// accepted; an add word first waits in S_BIN for the bit-serial quotient in
// the three axis lanes that run side by side, whose length is set by
// QB = clog2 of the largest axis bin count; an add whose axes all clamp
// skips the quotient. The next word is taken the cycle after the result is
// loaded, and a new result is loaded only once any older one held by m_tready
// has been taken. After reset a clearing pass writes zero to all
// BINS_X*BINS_Y*BINS_Z count entries, one per cycle, and no word is accepted
// until it ends. Write config only while no word is in flight.
// ----------------------------------------------------------------------------
`include "histogram_3d_binning_accumulator_top_macros.svh"

module histogram_3d_binning_accumulator_top
    import hist3d_pkg::*;
#(
    parameter int BINS_X     = DEF_BINS_X,
    parameter int BINS_Y     = DEF_BINS_Y,
    parameter int BINS_Z     = DEF_BINS_Z,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    // sample_x[31:0], sample_y[63:32], sample_z[95:64], read_bin[107:96]
    input  logic [111:0]      s_tdata,
    // cmd[0]
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // bin_number[11:0], bin_count[43:12], total_count[75:44],
    // out_of_range[76], halted[77]
    output logic [79:0]       m_tdata
);

    localparam int NB = BINS_X * BINS_Y * BINS_Z;
    localparam int FB = (NB > 1) ? $clog2(NB) : 1;
    localparam int CB = COUNT_BITS;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_BIN  = 3'd2;
    localparam logic [2:0] S_RA   = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;

    logic [2:0]  r_st;
    logic [31:0] r_min_x, r_min_y, r_min_z;
    logic [30:0] r_wid_x, r_wid_y, r_wid_z;
    logic        r_strict;
    logic        r_stopped;
    logic [CB-1:0] r_total;
    logic [FB-1:0] r_clr;
    logic        r_is_read;
    logic        r_rd_ok;
    logic [11:0] r_rbin;
    logic [FB-1:0] r_raddr;
    logic [CB-1:0] r_rdata;
    logic        r_ovalid;
    logic [79:0] r_odata;

    logic [CB-1:0] mem [NB];

    t_lane_res   res_x, res_y, res_z;
    logic        lane_start;
    logic        all_done;
    logic [FB-1:0] m_flat;
    logic        m_oor;
    logic        accept;
    logic        out_free;
    logic        upd_fire;
    logic        stop_nx;
    logic        count_it;
    logic [CB-1:0] inc_bin;
    logic [CB-1:0] inc_tot;
    logic [CB-1:0] show_bin;
    logic [CB-1:0] show_tot;
    logic [FB-1:0] mem_ra;
    logic        mem_we;
    logic [FB-1:0] mem_wa;
    logic [CB-1:0] mem_wd;

    assign s_tready   = (r_st == S_IDLE);
    assign accept     = s_tvalid & s_tready;
    assign lane_start = accept & (s_tuser == CMD_ADD);
    assign all_done   = res_x.done & res_y.done & res_z.done;
    assign out_free   = !r_ovalid | m_tready;
    assign upd_fire   = (r_st == S_UPD) & out_free;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x  <= MIN_RESET;
            r_min_y  <= MIN_RESET;
            r_min_z  <= MIN_RESET;
            r_wid_x  <= WIDTH_RESET;
            r_wid_y  <= WIDTH_RESET;
            r_wid_z  <= WIDTH_RESET;
            r_strict <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_X:   r_min_x  <= i_cfg_data;
                REG_MIN_Y:   r_min_y  <= i_cfg_data;
                REG_MIN_Z:   r_min_z  <= i_cfg_data;
                REG_WIDTH_X: r_wid_x  <= i_cfg_data[30:0];
                REG_WIDTH_Y: r_wid_y  <= i_cfg_data[30:0];
                REG_WIDTH_Z: r_wid_z  <= i_cfg_data[30:0];
                REG_STRICT:  r_strict <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    hist3d_axis_lane #(.BINS(BINS_X)) u_lane_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(lane_start),
        .i_sample(s_tdata[31:0]), .i_min(r_min_x), .i_width(r_wid_x), .o_res(res_x)
    );
    hist3d_axis_lane #(.BINS(BINS_Y)) u_lane_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(lane_start),
        .i_sample(s_tdata[63:32]), .i_min(r_min_y), .i_width(r_wid_y), .o_res(res_y)
    );
    hist3d_axis_lane #(.BINS(BINS_Z)) u_lane_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(lane_start),
        .i_sample(s_tdata[95:64]), .i_min(r_min_z), .i_width(r_wid_z), .o_res(res_z)
    );

    hist3d_merge #(.BINS_Y(BINS_Y), .BINS_Z(BINS_Z), .FB(FB)) u_merge (
        .i_clk(i_clk), .i_load((r_st == S_BIN) & all_done),
        .i_x(res_x), .i_y(res_y), .i_z(res_z), .o_flat(m_flat), .o_oor(m_oor)
    );

    // update step
    assign stop_nx  = r_stopped | (m_oor & r_strict);
    assign count_it = !r_is_read & !stop_nx;
    assign inc_bin  = (r_rdata == {CB{1'b1}}) ? r_rdata : r_rdata + CB'(1);
    assign inc_tot  = (r_total == {CB{1'b1}}) ? r_total : r_total + CB'(1);
    assign show_bin = r_is_read ? (r_rd_ok ? r_rdata : '0) : (count_it ? inc_bin : r_rdata);
    assign show_tot = count_it ? inc_tot : r_total;

    assign mem_ra = r_is_read ? r_raddr : m_flat;
    assign mem_we = (r_st == S_CLR) | (upd_fire & count_it);
    assign mem_wa = (r_st == S_CLR) ? r_clr : m_flat;
    assign mem_wd = (r_st == S_CLR) ? '0 : inc_bin;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (r_st == S_RA) r_rdata <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_CLR;
            r_clr     <= '0;
            r_stopped <= 1'b0;
            r_total   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            // load a new word, or drop the held one once taken
            if (upd_fire) r_ovalid <= 1'b1;
            else if (m_tready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + FB'(1);
                    if (r_clr == FB'(NB - 1)) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) r_st <= (s_tuser == CMD_READ) ? S_RA : S_BIN;
                end
                S_BIN: if (all_done) r_st <= S_RA;
                S_RA:  r_st <= S_UPD;
                S_UPD: begin
                    if (out_free) begin
                        r_st <= S_IDLE;
                        if (!r_is_read) begin
                            r_stopped <= stop_nx;
                            r_total   <= show_tot;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_read <= (s_tuser == CMD_READ);
            r_rbin    <= s_tdata[107:96];
            r_raddr   <= FB'(s_tdata[107:96]);
            r_rd_ok   <= 32'(s_tdata[107:96]) < 32'(NB);
        end
        if (upd_fire) begin
            r_odata[11:0]  <= r_is_read ? r_rbin : 12'(m_flat);
            r_odata[43:12] <= sat32(64'(show_bin));
            r_odata[75:44] <= sat32(64'(r_is_read ? r_total : show_tot));
            r_odata[76]    <= r_is_read ? 1'b0 : m_oor;
            r_odata[77]    <= r_is_read ? r_stopped : stop_nx;
            r_odata[79:78] <= 2'b00;
        end
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_odata;

    `H3D_ASSERT_NXT(a_stop_sticky, r_stopped, r_stopped)
    `H3D_ASSERT_IMP(a_we_place, mem_we, (r_st == S_CLR) || (r_st == S_UPD))
    `H3D_ASSERT_IMP(a_out_from_upd, $rose(r_ovalid), $past(r_st) == S_UPD)
    `H3D_ASSERT_IMP(a_total_hold, (r_st == S_BIN) || (r_st == S_RA), $stable(r_total))

endmodule
